// ===== rtl/core/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared definitions for the quaternion vector rotation core
// Default widths, the pipeline depth and the stage control bundle that the
// pipeline controller hands to the datapath.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Default signed width of one vector component.
  localparam int QVR_VEC_WIDTH      = 18;
  // Default number of fraction bits in a quaternion part (Q2.14).
  localparam int QVR_QUAT_FRAC_BITS = 14;
  // Fixed width of one quaternion part.
  localparam int QVR_QUAT_WIDTH     = 16;
  // Register stages from the input transaction to the output register.
  localparam int QVR_NUM_STAGES     = 5;

  // Per-stage control: load enables the stage's data registers, valid marks
  // that the stage holds an item.
  typedef struct packed {
    logic [QVR_NUM_STAGES-1:0] load;
    logic [QVR_NUM_STAGES-1:0] valid;
  } qvr_pipe_ctl_t;

endpackage

// ===== rtl/core/qvr_if.sv =====
// ----------------------------------------------------------------------------
// qvr_if: valid/ready channels of the quaternion vector rotation core
// The input channel carries a vector and a quaternion; the output channel
// carries the rotated vector and a saturation flag.
// ----------------------------------------------------------------------------
interface qvr_in_if import qvr_pkg::*; #(
  parameter int VEC_WIDTH = QVR_VEC_WIDTH
) ();
  logic                             valid;
  logic                             ready;
  logic signed [VEC_WIDTH-1:0]      vec_x;
  logic signed [VEC_WIDTH-1:0]      vec_y;
  logic signed [VEC_WIDTH-1:0]      vec_z;
  logic signed [QVR_QUAT_WIDTH-1:0] quat_w;
  logic signed [QVR_QUAT_WIDTH-1:0] quat_x;
  logic signed [QVR_QUAT_WIDTH-1:0] quat_y;
  logic signed [QVR_QUAT_WIDTH-1:0] quat_z;

  modport source (
    output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
    input  ready
  );
  modport sink (
    input  valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

interface qvr_out_if import qvr_pkg::*; #(
  parameter int VEC_WIDTH = QVR_VEC_WIDTH
) ();
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] rot_x;
  logic signed [VEC_WIDTH-1:0] rot_y;
  logic signed [VEC_WIDTH-1:0] rot_z;
  logic                        saturated;

  modport source (
    output valid, rot_x, rot_y, rot_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, saturated,
    output ready
  );
endinterface

// ===== rtl/core/qvr_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// qvr_pipe_ctrl: valid/ready control of the rotation pipeline
// Tracks which stages hold an item and lets each stage advance when the
// stage after it has room, so bubbles are squeezed out during a stall.
// ----------------------------------------------------------------------------
module qvr_pipe_ctrl import qvr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output qvr_pipe_ctl_t ctl_o
);

  localparam int N = QVR_NUM_STAGES;

  logic [N-1:0] valid_q;
  logic [N-1:0] valid_d;
  logic [N-1:0] upstream;
  logic [N:0]   ready;

  // A stage can take a new item when it is empty or its item moves on.
  always_comb begin
    ready[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign upstream = {valid_q[N-2:0], in_valid_i};
  assign valid_d  = (ready[N-1:0] & upstream) | (~ready[N-1:0] & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign ctl_o.load  = ready[N-1:0] & upstream;
  assign ctl_o.valid = valid_q;

`ifndef SYNTHESIS
  // A stage whose successor is blocked keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    |(valid_q & ~ready[N:1]) |=> (($past(valid_q & ~ready[N:1]) & ~valid_q) == '0))
    else $error("qvr_pipe_ctrl: blocked stage lost its item");

  // Items in flight change only by accepted and delivered transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(valid_q) == $countones($past(valid_q))
      + int'($past(in_valid_i && ready[0]))
      - int'($past(valid_q[N-1] && out_ready_i))))
    else $error("qvr_pipe_ctrl: item count not conserved");

  // Input is refused only when every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("qvr_pipe_ctrl: input refused with an empty stage");
`endif

endmodule

// ===== rtl/core/quaternion_vector_rotate_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core: fixed-point rotation of a vector by a
// quaternion, fully pipelined
// Computes t = w*v + q x v and then v + 2*(q x t) with rounding after each
// multiply stage and a saturating final add.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_ch) takes one transaction per vector: the vector
// (vec_x, vec_y, vec_z) and the quaternion (quat_w..quat_z, Q2.14 by default).
// The output channel (out_ch) returns one transaction per input transaction,
// in order: the rotated vector and a flag that is set when any component was
// clipped to the signed VEC_WIDTH range.
// A transaction passes through the five register stages and is delivered
// from stage 5 once the receiver is ready. Throughput is one transaction per
// cycle while the receiver is ready; the two multiply stages are the
// deepest logic, each one 16-bit by operand-width multiply per product.
// When the receiver stalls, items move up into empty stages, and in_ch.ready
// drops only once all five stages are full. Nothing is lost or repeated.
// Reset clears the stage valid bits only; the block keeps no other state.
// The interface instances must be built with the same VEC_WIDTH as the core.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_core import qvr_pkg::*; #(
  parameter int VEC_WIDTH      = QVR_VEC_WIDTH,
  parameter int QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qvr_in_if.sink     in_ch,
  qvr_out_if.source  out_ch
);

  localparam int N   = QVR_NUM_STAGES;
  localparam int QW  = QVR_QUAT_WIDTH;
  localparam int VW  = VEC_WIDTH;
  localparam int FB  = QUAT_FRAC_BITS;
  // First multiply: product, three-term sum, rounding width, rounded t.
  localparam int P1W = QW + VW;
  localparam int S1W = P1W + 2;
  localparam int A1W = ((S1W > FB + 1) ? S1W : FB + 1) + 1;
  localparam int TW  = A1W - FB;
  // Second multiply: product, doubled difference, rounding width, rounded r.
  localparam int P2W = QW + TW;
  localparam int S2W = P2W + 2;
  localparam int A2W = ((S2W > FB + 1) ? S2W : FB + 1) + 1;
  localparam int RW  = A2W - FB;
  // Final add of v and r before saturation.
  localparam int SW  = ((RW > VW) ? RW : VW) + 1;

  localparam logic signed [A1W-1:0] HALF1   = A1W'(1) <<< (FB - 1);
  localparam logic signed [A2W-1:0] HALF2   = A2W'(1) <<< (FB - 1);
  localparam logic signed [SW-1:0]  SUM_MAX = SW'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [SW-1:0]  SUM_MIN = ~SUM_MAX;
  localparam logic signed [VW-1:0]  ROT_MAX = VW'(SUM_MAX);
  localparam logic signed [VW-1:0]  ROT_MIN = VW'(SUM_MIN);

  // Saturate a sum to the vector range; the top bit of the result is the
  // clip flag, the rest is the clipped value.
  function automatic logic [VW:0] clip(input logic signed [SW-1:0] s);
    logic [VW:0] res;
    if (s > SUM_MAX) begin
      res = {1'b1, ROT_MAX};
    end else if (s < SUM_MIN) begin
      res = {1'b1, ROT_MIN};
    end else begin
      res = {1'b0, VW'(s)};
    end
    return res;
  endfunction

  qvr_pipe_ctl_t ctl;
  logic          in_ready;

  qvr_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .out_ready_i(out_ch.ready),
    .in_ready_o (in_ready),
    .ctl_o      (ctl)
  );

  assign in_ch.ready = in_ready;

  // Stage 1: the nine products of w*v + q x v. Names read as quaternion
  // part times vector part, e.g. s1_yz_q = qy * vz.
  logic signed [P1W-1:0] s1_wx_q, s1_yz_q, s1_zy_q;
  logic signed [P1W-1:0] s1_wy_q, s1_zx_q, s1_xz_q;
  logic signed [P1W-1:0] s1_wz_q, s1_xy_q, s1_yx_q;
  logic signed [VW-1:0]  s1_vx_q, s1_vy_q, s1_vz_q;
  logic signed [QW-1:0]  s1_qx_q, s1_qy_q, s1_qz_q;

  always_ff @(posedge clk_i) begin
    if (ctl.load[0]) begin
      s1_wx_q <= P1W'(in_ch.quat_w) * P1W'(in_ch.vec_x);
      s1_yz_q <= P1W'(in_ch.quat_y) * P1W'(in_ch.vec_z);
      s1_zy_q <= P1W'(in_ch.quat_z) * P1W'(in_ch.vec_y);
      s1_wy_q <= P1W'(in_ch.quat_w) * P1W'(in_ch.vec_y);
      s1_zx_q <= P1W'(in_ch.quat_z) * P1W'(in_ch.vec_x);
      s1_xz_q <= P1W'(in_ch.quat_x) * P1W'(in_ch.vec_z);
      s1_wz_q <= P1W'(in_ch.quat_w) * P1W'(in_ch.vec_z);
      s1_xy_q <= P1W'(in_ch.quat_x) * P1W'(in_ch.vec_y);
      s1_yx_q <= P1W'(in_ch.quat_y) * P1W'(in_ch.vec_x);
      s1_vx_q <= in_ch.vec_x;
      s1_vy_q <= in_ch.vec_y;
      s1_vz_q <= in_ch.vec_z;
      s1_qx_q <= in_ch.quat_x;
      s1_qy_q <= in_ch.quat_y;
      s1_qz_q <= in_ch.quat_z;
    end
  end

  // Stage 2: sum the products and round t to vector units. Halves round
  // toward plus infinity; t keeps full width and is not saturated.
  logic signed [TW-1:0] t0_d, t1_d, t2_d;
  logic signed [TW-1:0] s2_t0_q, s2_t1_q, s2_t2_q;
  logic signed [VW-1:0] s2_vx_q, s2_vy_q, s2_vz_q;
  logic signed [QW-1:0] s2_qx_q, s2_qy_q, s2_qz_q;

  assign t0_d = TW'((A1W'(s1_wx_q) + A1W'(s1_yz_q) - A1W'(s1_zy_q) + HALF1) >>> FB);
  assign t1_d = TW'((A1W'(s1_wy_q) + A1W'(s1_zx_q) - A1W'(s1_xz_q) + HALF1) >>> FB);
  assign t2_d = TW'((A1W'(s1_wz_q) + A1W'(s1_xy_q) - A1W'(s1_yx_q) + HALF1) >>> FB);

  always_ff @(posedge clk_i) begin
    if (ctl.load[1]) begin
      s2_t0_q <= t0_d;
      s2_t1_q <= t1_d;
      s2_t2_q <= t2_d;
      s2_vx_q <= s1_vx_q;
      s2_vy_q <= s1_vy_q;
      s2_vz_q <= s1_vz_q;
      s2_qx_q <= s1_qx_q;
      s2_qy_q <= s1_qy_q;
      s2_qz_q <= s1_qz_q;
    end
  end

  // Stage 3: the six products of q x t.
  logic signed [P2W-1:0] s3_yt2_q, s3_zt1_q, s3_zt0_q;
  logic signed [P2W-1:0] s3_xt2_q, s3_xt1_q, s3_yt0_q;
  logic signed [VW-1:0]  s3_vx_q, s3_vy_q, s3_vz_q;

  always_ff @(posedge clk_i) begin
    if (ctl.load[2]) begin
      s3_yt2_q <= P2W'(s2_qy_q) * P2W'(s2_t2_q);
      s3_zt1_q <= P2W'(s2_qz_q) * P2W'(s2_t1_q);
      s3_zt0_q <= P2W'(s2_qz_q) * P2W'(s2_t0_q);
      s3_xt2_q <= P2W'(s2_qx_q) * P2W'(s2_t2_q);
      s3_xt1_q <= P2W'(s2_qx_q) * P2W'(s2_t1_q);
      s3_yt0_q <= P2W'(s2_qy_q) * P2W'(s2_t0_q);
      s3_vx_q  <= s2_vx_q;
      s3_vy_q  <= s2_vy_q;
      s3_vz_q  <= s2_vz_q;
    end
  end

  // Stage 4: double the cross product difference and round it back.
  logic signed [RW-1:0] rx_d, ry_d, rz_d;
  logic signed [RW-1:0] s4_rx_q, s4_ry_q, s4_rz_q;
  logic signed [VW-1:0] s4_vx_q, s4_vy_q, s4_vz_q;

  assign rx_d = RW'((((A2W'(s3_yt2_q) - A2W'(s3_zt1_q)) <<< 1) + HALF2) >>> FB);
  assign ry_d = RW'((((A2W'(s3_zt0_q) - A2W'(s3_xt2_q)) <<< 1) + HALF2) >>> FB);
  assign rz_d = RW'((((A2W'(s3_xt1_q) - A2W'(s3_yt0_q)) <<< 1) + HALF2) >>> FB);

  always_ff @(posedge clk_i) begin
    if (ctl.load[3]) begin
      s4_rx_q <= rx_d;
      s4_ry_q <= ry_d;
      s4_rz_q <= rz_d;
      s4_vx_q <= s3_vx_q;
      s4_vy_q <= s3_vy_q;
      s4_vz_q <= s3_vz_q;
    end
  end

  // Stage 5: add v, saturate, and hold the result for the receiver.
  logic [VW:0]          cx_d, cy_d, cz_d;
  logic signed [VW-1:0] s5_rx_q, s5_ry_q, s5_rz_q;
  logic                 s5_sat_q;

  assign cx_d = clip(SW'(s4_vx_q) + SW'(s4_rx_q));
  assign cy_d = clip(SW'(s4_vy_q) + SW'(s4_ry_q));
  assign cz_d = clip(SW'(s4_vz_q) + SW'(s4_rz_q));

  always_ff @(posedge clk_i) begin
    if (ctl.load[4]) begin
      s5_rx_q  <= cx_d[VW-1:0];
      s5_ry_q  <= cy_d[VW-1:0];
      s5_rz_q  <= cz_d[VW-1:0];
      s5_sat_q <= cx_d[VW] | cy_d[VW] | cz_d[VW];
    end
  end

  assign out_ch.valid     = ctl.valid[N-1];
  assign out_ch.rot_x     = s5_rx_q;
  assign out_ch.rot_y     = s5_ry_q;
  assign out_ch.rot_z     = s5_rz_q;
  assign out_ch.saturated = s5_sat_q;

`ifndef SYNTHESIS
  // A clipped result always sits on a rail of the range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.saturated |->
      (out_ch.rot_x == ROT_MAX) || (out_ch.rot_x == ROT_MIN) ||
      (out_ch.rot_y == ROT_MAX) || (out_ch.rot_y == ROT_MIN) ||
      (out_ch.rot_z == ROT_MAX) || (out_ch.rot_z == ROT_MIN))
    else $error("qvr core: saturation flag set without a clipped component");

  // With the receiver ready the pipeline always has room for a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.ready |-> in_ch.ready)
    else $error("qvr core: input stalled while output is ready");

  // A result appears only after passing through the stage before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(ctl.valid[N-2]))
    else $error("qvr core: result appeared without a preceding stage");
`endif

endmodule
